// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tick scheduler RTL.
// No dependencies; concurrent assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle that implies a result in the next cycle.
`define TTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== rtl/tts_pkg.sv =====
// Package for the tick scheduler: field widths, default sizes and the opcode type.
// No dependencies; used by the channel interfaces and the top level.
package tts_pkg;

    localparam int unsigned PERIODIC_SLOTS_DEF  = 4;
    localparam int unsigned ONESHOT_SLOTS_DEF   = 8;
    localparam int unsigned TICKS_PER_MILLI_DEF = 1;

    localparam int unsigned COUNT_W         = 26;
    localparam int unsigned MS_W            = 16;
    localparam int unsigned SLOT_W          = 3;
    localparam int unsigned PFIRE_W         = 4;
    localparam int unsigned OFIRE_W         = 8;
    localparam int unsigned NUM_PERIOD_REGS = 4;
    localparam int unsigned PADDR_W         = $clog2(NUM_PERIOD_REGS) + 2;
    localparam int unsigned PDATA_W         = 32;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ADD  = 1'b1
    } t_opcode;

    typedef logic [COUNT_W-1:0] t_count;

endpackage

// ===== rtl/tts_cmd_if.sv =====
// Command channel of the tick scheduler: valid/ready plus opcode and delay.
// Depends on tts_pkg.
interface tts_cmd_if import tts_pkg::*; ();
    logic            valid;
    logic            ready;
    t_opcode         opcode;
    logic [MS_W-1:0] delay_ms;

    modport source (output valid, output opcode, output delay_ms, input ready);
    modport sink   (input valid, input opcode, input delay_ms, output ready);
endinterface

// ===== rtl/tts_rsp_if.sv =====
// Response channel of the tick scheduler: valid/ready plus result fields.
// Depends on tts_pkg.
interface tts_rsp_if import tts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    logic [PFIRE_W-1:0] periodic_fire;
    logic [OFIRE_W-1:0] oneshot_fire;

    modport source (output valid, output accepted, output slot, output periodic_fire,
                    output oneshot_fire, input ready);
    modport sink   (input valid, input accepted, input slot, input periodic_fire,
                    input oneshot_fire, output ready);
endinterface

// ===== rtl/tick_task_scheduler.sv =====
// Tick scheduler with periodic channels and one-shot slots.
// Depends on tts_pkg, tts_cmd_if, tts_rsp_if and assert_macros.svh.
//
// Usage: each command beat on i_cmd is either a tick (one system tick has
// elapsed) or an add (place a one-shot delay in the lowest free slot). Every
// command beat yields exactly one response beat on o_rsp, in order. A tick
// response carries the fire masks of the periodic channels and one-shot
// slots; an add response carries the granted slot, or accepted low when all
// slots are busy. Channel periods are written over the APB port while idle;
// a nonzero period reloads that channel's countdown immediately.
// The edge that accepts a command loads the input register. Once the response
// register is free, a single pass updates every counter in parallel and loads
// the response register. Throughput is one command per cycle while the receiver
// keeps taking responses, set by that single counter-update pass.
// When the receiver stalls, the response register holds and one more command
// still enters the input register; after that i_cmd.ready drops until the
// response is taken. Reset clears all periods, marks every one-shot slot free
// and empties both stages.
`include "assert_macros.svh"

module tick_task_scheduler import tts_pkg::*; #(
    parameter int unsigned PERIODIC_SLOTS  = PERIODIC_SLOTS_DEF,
    parameter int unsigned ONESHOT_SLOTS   = ONESHOT_SLOTS_DEF,
    parameter int unsigned TICKS_PER_MILLI = TICKS_PER_MILLI_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tts_cmd_if.sink            i_cmd,
    tts_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Only channels that have a period register can ever become active.
    localparam int unsigned CFG_CH    = (PERIODIC_SLOTS < NUM_PERIOD_REGS) ?
                                        PERIODIC_SLOTS : NUM_PERIOD_REGS;
    localparam int unsigned OS_IDX_W  = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;

    // Input stage.
    logic    r_s1_valid;
    t_opcode r_s1_op;
    t_count  r_s1_ticks;

    // Response register.
    logic               r_out_valid;
    logic               r_out_accepted;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [PFIRE_W-1:0] r_out_pfire;
    logic [OFIRE_W-1:0] r_out_ofire;

    // Scheduler state.
    logic [MS_W-1:0]          r_period [PERIODIC_SLOTS];
    t_count                   r_reload [PERIODIC_SLOTS];
    t_count                   r_pcount [PERIODIC_SLOTS];
    t_count                   r_ocount [ONESHOT_SLOTS];
    logic [ONESHOT_SLOTS-1:0] r_busy;

    // Next values from the update pass.
    t_count                    n_pcount [PERIODIC_SLOTS];
    t_count                    n_ocount [ONESHOT_SLOTS];
    logic [ONESHOT_SLOTS-1:0]  n_busy;
    logic [PERIODIC_SLOTS-1:0] n_pfire;
    logic [ONESHOT_SLOTS-1:0]  n_ofire;
    logic                      n_accepted;
    logic [SLOT_W-1:0]         n_slot;
    logic [OS_IDX_W-1:0]       n_idx;
    logic                      n_found;

    logic                 out_free;
    logic                 s1_go;
    logic                 in_acc;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    t_count               cfg_ticks;
    t_count               in_ticks;

    // Handshake: the response register frees when empty or being taken, and
    // the input stage moves whenever the response register is free.
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_go       = r_s1_valid && out_free;
    assign i_cmd.ready = !r_s1_valid || out_free;
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    // Milliseconds to ticks; the product fits the 26-bit count for TICKS_PER_MILLI up to 1024.
    assign in_ticks  = i_cmd.delay_ms * COUNT_W'(TICKS_PER_MILLI);
    assign cfg_ticks = pwdata[MS_W-1:0] * COUNT_W'(TICKS_PER_MILLI);

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    // Register readback; registers without a channel read as zero.
    always_comb begin
        prdata = '0;
        for (int i = 0; i < CFG_CH; i++) begin
            if (cfg_idx == REG_IDX_W'(i)) begin
                prdata = PDATA_W'(r_period[i]);
            end
        end
    end

    // Single update pass over all channels and slots.
    always_comb begin
        n_pfire    = '0;
        n_ofire    = '0;
        n_accepted = 1'b0;
        n_busy     = r_busy;
        n_idx      = '0;
        n_found    = 1'b0;
        for (int i = 0; i < PERIODIC_SLOTS; i++) begin
            n_pcount[i] = r_pcount[i];
        end
        for (int i = 0; i < ONESHOT_SLOTS; i++) begin
            n_ocount[i] = r_ocount[i];
        end

        // Lowest free one-shot slot: scan downward so the lowest one wins.
        for (int i = ONESHOT_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                n_found = 1'b1;
                n_idx   = OS_IDX_W'(i);
            end
        end

        if (r_s1_op == OP_TICK) begin
            n_accepted = 1'b1;
            for (int i = 0; i < PERIODIC_SLOTS; i++) begin
                if (r_period[i] != '0) begin
                    if (r_pcount[i] <= t_count'(1)) begin
                        // A count of zero means the last reload was already due,
                        // so the fresh period starts one tick short.
                        n_pfire[i]  = 1'b1;
                        n_pcount[i] = (r_pcount[i] == t_count'(1)) ?
                                      r_reload[i] : r_reload[i] - t_count'(1);
                    end else begin
                        n_pcount[i] = r_pcount[i] - t_count'(1);
                    end
                end
            end
            for (int i = 0; i < ONESHOT_SLOTS; i++) begin
                if (r_busy[i]) begin
                    if (r_ocount[i] <= t_count'(1)) begin
                        n_ofire[i]  = 1'b1;
                        n_busy[i]   = 1'b0;
                        n_ocount[i] = '0;
                    end else begin
                        n_ocount[i] = r_ocount[i] - t_count'(1);
                    end
                end
            end
        end else if (n_found) begin
            n_accepted = 1'b1;
            for (int i = 0; i < ONESHOT_SLOTS; i++) begin
                if (n_idx == OS_IDX_W'(i)) begin
                    n_busy[i]   = 1'b1;
                    n_ocount[i] = r_s1_ticks;
                end
            end
        end

        n_slot = (r_s1_op == OP_ADD && n_found) ? SLOT_W'(n_idx) : '0;
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            for (int i = 0; i < PERIODIC_SLOTS; i++) begin
                r_period[i] <= '0;
                r_reload[i] <= '0;
            end
        end else begin
            r_s1_valid <= in_acc || (r_s1_valid && !s1_go);
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_go) begin
                r_busy <= n_busy;
            end
            for (int i = 0; i < CFG_CH; i++) begin
                if (cfg_wr && cfg_idx == REG_IDX_W'(i)) begin
                    r_period[i] <= pwdata[MS_W-1:0];
                    r_reload[i] <= cfg_ticks;
                end
            end
        end
    end

    // Payload: input stage, counters and response fields.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_cmd.opcode;
            r_s1_ticks <= in_ticks;
        end
        if (s1_go) begin
            r_out_accepted <= n_accepted;
            r_out_slot     <= n_slot;
            r_out_pfire    <= PFIRE_W'(n_pfire);
            r_out_ofire    <= OFIRE_W'(n_ofire);
            for (int i = 0; i < ONESHOT_SLOTS; i++) begin
                r_ocount[i] <= n_ocount[i];
            end
        end
        for (int i = 0; i < PERIODIC_SLOTS; i++) begin
            // A nonzero period write reloads the countdown at once.
            if (i < CFG_CH && cfg_wr && cfg_idx == REG_IDX_W'(i)
                && pwdata[MS_W-1:0] != '0) begin
                r_pcount[i] <= cfg_ticks;
            end else if (s1_go) begin
                r_pcount[i] <= n_pcount[i];
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.accepted      = r_out_accepted;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.periodic_fire = r_out_pfire;
    assign o_rsp.oneshot_fire  = r_out_ofire;

    // A rejected add beat carries no slot and no fire bits.
    `TTS_ASSERT(a_reject_clean, i_clk, i_rst_n, !(r_out_valid && !r_out_accepted) || (r_out_slot == '0 && r_out_pfire == '0 && r_out_ofire == '0), "rejected add with nonzero fields")
    // A tick only frees slots and never claims one.
    `TTS_ASSERT_NEXT(a_tick_no_claim, i_clk, i_rst_n, s1_go && r_s1_op == OP_TICK, (r_busy & ~$past(r_busy)) == '0, "tick claimed a one-shot slot")
    // A placed add claims exactly one slot.
    `TTS_ASSERT_NEXT(a_add_one_slot, i_clk, i_rst_n, s1_go && r_s1_op == OP_ADD && n_found, $countones(r_busy) == $countones($past(r_busy)) + 1, "add did not claim exactly one slot")
    // A full slot set rejects the add.
    `TTS_ASSERT(a_full_rejects, i_clk, i_rst_n, !(r_s1_valid && r_s1_op == OP_ADD && r_busy == '1) || !n_accepted, "add accepted with all slots busy")

endmodule

// ===== dv/tb_tick_task_scheduler.sv =====
// Self-checking testbench for tick_task_scheduler: directed and random command beats,
// APB period programming and a scoreboard class that predicts every response beat.
// Depends on tts_pkg, tts_cmd_if, tts_rsp_if and the tick_task_scheduler RTL.
import tts_pkg::*;

// One predicted or observed response beat.
typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    logic [PFIRE_W-1:0] periodic_fire;
    logic [OFIRE_W-1:0] oneshot_fire;
} t_sched_result;

// Scheduler shadow state plus the queue of response beats still owed by the block.
class tick_scoreboard;
    logic [MS_W-1:0] period [PERIODIC_SLOTS_DEF];
    t_count          chan_count [PERIODIC_SLOTS_DEF];
    t_count          shot_count [ONESHOT_SLOTS_DEF];
    logic            shot_busy [ONESHOT_SLOTS_DEF];
    t_sched_result   owed_q [$];
    int unsigned     mismatches;
    int unsigned     ticks;
    int unsigned     adds;
    int unsigned     rejects;
    int unsigned     chan_fires;
    int unsigned     shot_fires;

    function new();
        for (int i = 0; i < PERIODIC_SLOTS_DEF; i++) begin
            period[i]     = '0;
            chan_count[i] = '0;
        end
        for (int i = 0; i < ONESHOT_SLOTS_DEF; i++) begin
            shot_count[i] = '0;
            shot_busy[i]  = 1'b0;
        end
        mismatches = 0;
        ticks      = 0;
        adds       = 0;
        rejects    = 0;
        chan_fires = 0;
        shot_fires = 0;
    endfunction

    function t_count ms_to_ticks(logic [MS_W-1:0] ms);
        return t_count'(32'(ms) * TICKS_PER_MILLI_DEF);
    endfunction

    function void write_period(int unsigned idx, logic [MS_W-1:0] value);
        if (idx >= NUM_PERIOD_REGS) return;
        period[idx] = value;
        if (value != '0) chan_count[idx] = ms_to_ticks(value);
    endfunction

    function void note_command(t_opcode op, logic [MS_W-1:0] dly_ms);
        t_sched_result r;
        t_count        reload;
        logic          placed;
        r      = '0;
        placed = 1'b0;
        if (op == OP_TICK) begin
            r.accepted = 1'b1;
            ticks++;
            for (int i = 0; i < PERIODIC_SLOTS_DEF; i++) begin
                if (period[i] != '0) begin
                    if (chan_count[i] <= 1) begin
                        reload             = ms_to_ticks(period[i]);
                        r.periodic_fire[i] = 1'b1;
                        chan_count[i]      = (chan_count[i] == 1) ? reload : reload - 1'b1;
                    end else begin
                        chan_count[i] = chan_count[i] - 1'b1;
                    end
                end
            end
            for (int i = 0; i < ONESHOT_SLOTS_DEF; i++) begin
                if (shot_busy[i]) begin
                    if (shot_count[i] <= 1) begin
                        r.oneshot_fire[i] = 1'b1;
                        shot_busy[i]      = 1'b0;
                        shot_count[i]     = '0;
                    end else begin
                        shot_count[i] = shot_count[i] - 1'b1;
                    end
                end
            end
            chan_fires += $countones(r.periodic_fire);
            shot_fires += $countones(r.oneshot_fire);
        end else begin
            adds++;
            for (int i = 0; i < ONESHOT_SLOTS_DEF; i++) begin
                if (!placed && !shot_busy[i]) begin
                    placed        = 1'b1;
                    shot_busy[i]  = 1'b1;
                    shot_count[i] = ms_to_ticks(dly_ms);
                    r.accepted    = 1'b1;
                    r.slot        = SLOT_W'(i);
                end
            end
            if (!placed) rejects++;
        end
        owed_q.push_back(r);
    endfunction

    function void check_response(t_sched_result got);
        t_sched_result want;
        if (owed_q.size() == 0) begin
            $error("response beat arrived with no command outstanding");
            mismatches++;
            return;
        end
        want = owed_q.pop_front();
        if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            mismatches++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            mismatches++;
        end
        if (got.periodic_fire !== want.periodic_fire) begin
            $error("periodic_fire: expected 0x%0h, got 0x%0h",
                   want.periodic_fire, got.periodic_fire);
            mismatches++;
        end
        if (got.oneshot_fire !== want.oneshot_fire) begin
            $error("oneshot_fire: expected 0x%0h, got 0x%0h",
                   want.oneshot_fire, got.oneshot_fire);
            mismatches++;
        end
    endfunction

    function int unsigned pending();
        return owed_q.size();
    endfunction
endclass

module tb_tick_task_scheduler;

    // Generous bound: several tens of times the slowest expected run.
    localparam int unsigned CYCLE_LIMIT = 150000;
    // Length of each long receiver hold-off in the pressure phase.
    localparam int unsigned HOLD_LEN    = 40;
    localparam int unsigned PHASE_ITEMS = 170;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tts_cmd_if cmd_if ();
    tts_rsp_if rsp_if ();

    tick_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tick_scoreboard sb = new();

    // Idle percentages of the two sides; the main process sets them per phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // A hold-off is requested by the main process and counted down by the receiver.
    logic        hold_request   = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned holds_done     = 0;
    int unsigned settings_done  = 0;
    int unsigned cycle_count    = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Every input of the block holds a known value from time zero.
    initial begin
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.opcode   = OP_TICK;
        cmd_if.delay_ms = '0;
        rsp_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
    end

    // Watchdog: the run must finish well inside the cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: ready changes on the falling edge. A requested hold-off keeps ready low
    // during a HOLD_LEN countdown, so the block fills up and drops its command ready.
    always begin
        @(negedge i_clk);
        if (hold_request) begin
            hold_left    = HOLD_LEN;
            hold_request = 1'b0;
            holds_done++;
        end
        if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
        end else begin
            rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every response beat is sampled at the rising edge and compared with the oldest
    // outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response('{accepted:      rsp_if.accepted,
                                slot:          rsp_if.slot,
                                periodic_fire: rsp_if.periodic_fire,
                                oneshot_fire:  rsp_if.oneshot_fire});
        end
    end

    // Offer one command beat, inserting random idle cycles first, and record it in
    // the scoreboard at the edge where it is accepted. Valid stays high on return
    // so that back-to-back beats need no gap.
    task automatic send_beat(input t_opcode op, input logic [MS_W-1:0] dly_ms);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid    = 1'b1;
        cmd_if.opcode   = op;
        cmd_if.delay_ms = dly_ms;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        sb.note_command(op, dly_ms);
    endtask

    // Drop valid and wait until every outstanding response beat has been taken,
    // then let the pipeline drain.
    task automatic drain();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at the
    // edge where psel, penable, pwrite and pready are all high.
    task automatic apb_write(input int unsigned idx, input logic [MS_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx * 4);
        pwdata  = PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_period(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Program all four channel periods; only called while the block is idle.
    task automatic set_periods(input logic [MS_W-1:0] p0, input logic [MS_W-1:0] p1,
                               input logic [MS_W-1:0] p2, input logic [MS_W-1:0] p3);
        apb_write(0, p0);
        apb_write(1, p1);
        apb_write(2, p2);
        apb_write(3, p3);
        settings_done++;
    endtask

    // Random command: a little over half ticks. Add delays are mostly short so that
    // slots free up again; a rare full-range delay parks a slot for the whole run.
    // Ticks carry a random delay field, which the block must ignore.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic pressure);
        t_opcode         op;
        logic [MS_W-1:0] dly_ms;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                op     = OP_TICK;
                dly_ms = MS_W'($urandom);
            end else begin
                op = OP_ADD;
                if ($urandom_range(0, 255) == 0)
                    dly_ms = MS_W'($urandom);
                else if ($urandom_range(0, 9) < 7)
                    dly_ms = MS_W'($urandom_range(0, 8));
                else
                    dly_ms = MS_W'($urandom_range(9, 40));
            end
            if (pressure && (k % 60 == 5)) hold_request = 1'b1;
            send_beat(op, dly_ms);
        end
        drain();
    endtask

    // Mostly small periods so channels fire often, now and then a full-range value.
    function automatic logic [MS_W-1:0] random_period();
        if ($urandom_range(0, 3) == 0) return MS_W'($urandom);
        return MS_W'($urandom_range(0, 12));
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part: extreme periods (fastest, every other tick, off, slowest).
        set_periods(16'd1, 16'd2, 16'd0, 16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(OP_TICK, 16'h0000);
        // A zero delay fires on the very next tick.
        send_beat(OP_ADD,  16'd0);
        send_beat(OP_TICK, 16'hFFFF);
        send_beat(OP_ADD,  16'd1);
        // The longest delay parks a slot for the rest of the run.
        send_beat(OP_ADD,  16'hFFFF);
        send_beat(OP_ADD,  16'd2);
        send_beat(OP_TICK, 16'h0000);
        // Fill every remaining slot, then two adds that find no free slot.
        send_beat(OP_ADD,  16'd3);
        send_beat(OP_ADD,  16'd4);
        send_beat(OP_ADD,  16'd5);
        send_beat(OP_ADD,  16'd6);
        send_beat(OP_ADD,  16'd7);
        send_beat(OP_ADD,  16'd1);
        send_beat(OP_ADD,  16'h5555);
        send_beat(OP_ADD,  16'hAAAA);
        // Let the short delays run out, then an add lands in the lowest freed slot.
        repeat (7) send_beat(OP_TICK, 16'h0000);
        send_beat(OP_ADD,  16'd0);
        send_beat(OP_TICK, 16'h0000);
        drain();

        // Random part. Each phase rewrites periods: a nonzero value restarts a stopped
        // channel or reloads a running one, and a zero value stops it.
        set_periods(16'd3, 16'd5, 16'd7, 16'd11);
        run_phase(0, 0, 1'b0);
        set_periods(16'd1, 16'd0, 16'd13, 16'd4);
        run_phase(61, 0, 1'b0);
        set_periods(random_period(), random_period(), random_period(), random_period());
        run_phase(0, 61, 1'b0);
        set_periods(16'hFFFF, 16'd1, 16'd2, 16'd0);
        run_phase(6, 6, 1'b0);
        // Pressure: the receiver holds off for long stretches while commands keep coming.
        set_periods(16'd2, 16'd3, 16'd1, 16'd9);
        run_phase(0, 0, 1'b1);
        set_periods(random_period(), random_period(), random_period(), random_period());
        run_phase(30, 30, 1'b0);

        repeat (10) @(posedge i_clk);
        $display("Checked %0d commands: %0d ticks, %0d adds (%0d rejected, no free slot).",
                 sb.ticks + sb.adds, sb.ticks, sb.adds, sb.rejects);
        $display("%0d period settings, %0d long receiver hold-offs,", settings_done,
                 holds_done);
        $display("%0d periodic and %0d one-shot fires.", sb.chan_fires, sb.shot_fires);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_cmd_if.sv
rtl/tts_rsp_if.sv
rtl/tick_task_scheduler.sv
dv/tb_tick_task_scheduler.sv
